/* src/wccs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wccs_pkg: shared types and constants of the wake/command sequencer
// Item and result payloads, configuration registers, command and outcome
// codes, and the command decode used when a command is executed.
// ----------------------------------------------------------------------------
package wccs_pkg;

	// Configuration register indexes
	localparam int CfgIndexW = 2;
	typedef enum logic [CfgIndexW-1:0] {
		CFG_WAKE_FRAMES    = 2'd0,
		CFG_COMMAND_FRAMES = 2'd1,
		CFG_LISTEN_WINDOW  = 2'd2,
		CFG_COOLDOWN       = 2'd3
	} cfg_index_t;

	localparam int CfgDataW = 32;

	// Register reset values
	localparam logic [7:0]  WakeFramesRst    = 8'd3;
	localparam logic [7:0]  CommandFramesRst = 8'd3;
	localparam logic [31:0] ListenWindowRst  = 32'd5000;
	localparam logic [31:0] CooldownRst      = 32'd500;

	// Command ids carried by a classifier result
	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_LIGHT_ON  = 3'd1,
		CMD_LIGHT_OFF = 3'd2,
		CMD_FAN_ON    = 3'd3,
		CMD_FAN_OFF   = 3'd4,
		CMD_OTHER     = 3'd5
	} cmd_id_t;

	// Outcome codes of a result
	typedef enum logic [2:0] {
		OUT_NOTHING    = 3'd0,
		OUT_NO_COMMAND = 3'd1,
		OUT_LIGHT_ON   = 3'd2,
		OUT_LIGHT_OFF  = 3'd3,
		OUT_FAN_ON     = 3'd4,
		OUT_FAN_OFF    = 3'd5,
		OUT_UNKNOWN    = 3'd6
	} outcome_t;

	typedef struct packed {
		logic [7:0]  wake_frames_needed;
		logic [7:0]  command_frames_needed;
		logic [31:0] listen_window_ms;
		logic [31:0] cooldown_ms;
	} cfg_t;

	typedef struct packed {
		logic        mode;
		logic [31:0] now_ms;
		logic        is_wake;
		logic        has_command;
		logic [7:0]  label_id;
		logic [2:0]  command_id;
	} item_t;

	typedef struct packed {
		logic       timed_out;
		logic       wake_activated;
		logic [2:0] command_outcome;
		logic       light_level;
		logic       fan_level;
		logic       listening;
	} result_t;

	// Outcome of executing a command id; ids above the known set are unknown
	function automatic logic [2:0] cmd_outcome(input logic [2:0] cmd);
		logic [2:0] res;
		unique case (cmd)
			CMD_NONE:      res = OUT_NO_COMMAND;
			CMD_LIGHT_ON:  res = OUT_LIGHT_ON;
			CMD_LIGHT_OFF: res = OUT_LIGHT_OFF;
			CMD_FAN_ON:    res = OUT_FAN_ON;
			CMD_FAN_OFF:   res = OUT_FAN_OFF;
			default:       res = OUT_UNKNOWN;
		endcase
		return res;
	endfunction

endpackage

/* src/wccs_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wccs_core: sequencer state and per-item update
// Holds the listen state, wake and command counters and output levels.
// Computes the result of the item in the input register; the state moves
// on when that item advances into the result register.
// ----------------------------------------------------------------------------
module wccs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  wccs_pkg::item_t   item_s1,
	input  wccs_pkg::cfg_t    cfg,
	output wccs_pkg::result_t res
);
	import wccs_pkg::*;

	logic        active_q;
	logic [31:0] act_time_q;
	logic        wake_pend_q;
	logic [7:0]  wake_cnt_q;
	logic        cmd_pend_q;
	logic [7:0]  cmd_label_q;
	logic [2:0]  cmd_action_q;
	logic [7:0]  cmd_cnt_q;
	logic        light_q;
	logic        fan_q;

	logic        active_d;
	logic [31:0] act_time_d;
	logic        wake_pend_d;
	logic [7:0]  wake_cnt_d;
	logic        cmd_pend_d;
	logic [7:0]  cmd_label_d;
	logic [2:0]  cmd_action_d;
	logic [7:0]  cmd_cnt_d;
	logic        light_d;
	logic        fan_d;

	logic [31:0] elapsed;
	logic        timeout;
	logic        wake_conf;
	logic        cmd_conf;
	logic [2:0]  outcome;

	// Modular time since activation
	assign elapsed = item_s1.now_ms - act_time_q;
	assign timeout = active_q && (elapsed >= cfg.listen_window_ms);

	// Next state and result of the current item
	always_comb begin
		active_d     = active_q;
		act_time_d   = act_time_q;
		wake_pend_d  = wake_pend_q;
		wake_cnt_d   = wake_cnt_q;
		cmd_pend_d   = cmd_pend_q;
		cmd_label_d  = cmd_label_q;
		cmd_action_d = cmd_action_q;
		cmd_cnt_d    = cmd_cnt_q;
		light_d      = light_q;
		fan_d        = fan_q;
		wake_conf    = 1'b0;
		cmd_conf     = 1'b0;
		outcome      = OUT_NOTHING;

		// timeout is checked first and leaves the block idle
		if (timeout) begin
			active_d     = 1'b0;
			wake_pend_d  = 1'b0;
			wake_cnt_d   = 8'd0;
			cmd_pend_d   = 1'b0;
			cmd_label_d  = 8'd0;
			cmd_action_d = CMD_NONE;
			cmd_cnt_d    = 8'd0;
		end

		if (item_s1.mode) begin
			if (!active_d) begin
				// idle: count wake frames, saturating
				if (!item_s1.is_wake) begin
					wake_pend_d = 1'b0;
					wake_cnt_d  = 8'd0;
				end else if (!wake_pend_d) begin
					wake_pend_d = 1'b1;
					wake_cnt_d  = 8'd1;
					wake_conf   = cfg.wake_frames_needed <= 8'd1;
				end else begin
					if (wake_cnt_d < cfg.wake_frames_needed)
						wake_cnt_d = wake_cnt_d + 8'd1;
					wake_conf = wake_cnt_d >= cfg.wake_frames_needed;
				end
				if (wake_conf) begin
					active_d     = 1'b1;
					act_time_d   = item_s1.now_ms;
					wake_pend_d  = 1'b0;
					wake_cnt_d   = 8'd0;
					cmd_pend_d   = 1'b0;
					cmd_label_d  = 8'd0;
					cmd_action_d = CMD_NONE;
					cmd_cnt_d    = 8'd0;
				end
			end else if ((elapsed >= cfg.cooldown_ms) && !item_s1.is_wake) begin
				// listening past cooldown: count same-label commands
				if (!item_s1.has_command) begin
					cmd_pend_d   = 1'b0;
					cmd_label_d  = 8'd0;
					cmd_action_d = CMD_NONE;
					cmd_cnt_d    = 8'd0;
				end else if (!cmd_pend_d || (cmd_label_d != item_s1.label_id)) begin
					cmd_pend_d   = 1'b1;
					cmd_label_d  = item_s1.label_id;
					cmd_action_d = item_s1.command_id;
					cmd_cnt_d    = 8'd1;
					cmd_conf     = cfg.command_frames_needed <= 8'd1;
				end else begin
					if (cmd_cnt_d < cfg.command_frames_needed)
						cmd_cnt_d = cmd_cnt_d + 8'd1;
					cmd_action_d = item_s1.command_id;
					cmd_conf     = cmd_cnt_d >= cfg.command_frames_needed;
				end
				if (cmd_conf) begin
					outcome = cmd_outcome(cmd_action_d);
					unique case (cmd_action_d)
						CMD_LIGHT_ON:  light_d = 1'b1;
						CMD_LIGHT_OFF: light_d = 1'b0;
						CMD_FAN_ON:    fan_d   = 1'b1;
						CMD_FAN_OFF:   fan_d   = 1'b0;
						default: ;
					endcase
					active_d     = 1'b0;
					wake_pend_d  = 1'b0;
					wake_cnt_d   = 8'd0;
					cmd_pend_d   = 1'b0;
					cmd_label_d  = 8'd0;
					cmd_action_d = CMD_NONE;
					cmd_cnt_d    = 8'd0;
				end
			end
		end
	end

	// Result fields
	always_comb begin
		res.timed_out       = timeout;
		res.wake_activated  = wake_conf;
		res.command_outcome = outcome;
		res.light_level     = light_d;
		res.fan_level       = fan_d;
		res.listening       = active_d;
	end

	// State registers, updated as the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			act_time_q   <= 32'd0;
			wake_pend_q  <= 1'b0;
			wake_cnt_q   <= 8'd0;
			cmd_pend_q   <= 1'b0;
			cmd_label_q  <= 8'd0;
			cmd_action_q <= CMD_NONE;
			cmd_cnt_q    <= 8'd0;
			light_q      <= 1'b0;
			fan_q        <= 1'b0;
		end else if (step) begin
			active_q     <= active_d;
			act_time_q   <= act_time_d;
			wake_pend_q  <= wake_pend_d;
			wake_cnt_q   <= wake_cnt_d;
			cmd_pend_q   <= cmd_pend_d;
			cmd_label_q  <= cmd_label_d;
			cmd_action_q <= cmd_action_d;
			cmd_cnt_q    <= cmd_cnt_d;
			light_q      <= light_d;
			fan_q        <= fan_d;
		end
	end

endmodule

/* src/wake_command_confirm_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wake_command_confirm_sequencer: wake word and command confirmation
//
// Usage: each input item on item/item_valid/item_stall is one time tick,
// optionally with a keyword-classifier result (mode = 1). For every item the
// block returns exactly one result on result/result_valid/result_stall:
// timeout and wake flags, the executed command outcome, the light and fan
// levels and whether the block is listening.
// Pipeline: an accepted item is registered in the item register, processed
// by the core and its result is registered in the result register once that
// register is free (two register stages). Throughput: one item per cycle
// while no result is stalled, set by the state update between the registers.
// Stall: when result_stall holds a waiting result, the item register still
// takes one more item; item_stall rises only when both stages are full.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
// the user must write them only while the block is idle, which the block
// does not enforce. Reset clears all state and loads the register defaults.
// ----------------------------------------------------------------------------
module wake_command_confirm_sequencer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  wccs_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output wccs_pkg::result_t                   result,
	input  logic                                cfg_we,
	input  logic [wccs_pkg::CfgIndexW-1:0]      cfg_index,
	input  logic [wccs_pkg::CfgDataW-1:0]       cfg_data
);
	import wccs_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	result_t res_d;
	logic    out_free;
	logic    step;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wake_frames_needed    <= WakeFramesRst;
			cfg_q.command_frames_needed <= CommandFramesRst;
			cfg_q.listen_window_ms      <= ListenWindowRst;
			cfg_q.cooldown_ms           <= CooldownRst;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_WAKE_FRAMES:    cfg_q.wake_frames_needed    <= cfg_data[7:0];
				CFG_COMMAND_FRAMES: cfg_q.command_frames_needed <= cfg_data[7:0];
				CFG_LISTEN_WINDOW:  cfg_q.listen_window_ms      <= cfg_data;
				CFG_COOLDOWN:       cfg_q.cooldown_ms           <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: result register frees up when empty or taken
	assign out_free   = !valid_s2 || !result_stall;
	assign step       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// Item register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!item_stall)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	wccs_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.res     (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (out_free)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step)
			result_s2 <= res_d;
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

/* test/wake_command_confirm_sequencer_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wake_command_confirm_sequencer_tb: self-checking bench for the sequencer
// Drives wake/command items through the valid/stall item channel and checks
// every status result against a cycle-free model of the confirmation logic.
// Directed items cover wake and command counting, wrap of the millisecond
// clock, timeout together with wake, label changes and cleared counts. Long
// counts, window and cooldown extremes and random sessions follow, under
// several sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module wake_command_confirm_sequencer_tb;
	import wccs_pkg::*;

	// Command ids outside the named set; both execute as unknown
	localparam logic [2:0] CMD_ID_RSVD6 = 3'd6;
	localparam logic [2:0] CMD_ID_RSVD7 = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CfgIndexW-1:0] cfg_index = CFG_WAKE_FRAMES;
	logic [CfgDataW-1:0] cfg_data = '0;

	wake_command_confirm_sequencer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 4 ns clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Register shadow and model state of the sequencer
	cfg_t        cfg_shadow;
	logic        mdl_listening;
	logic [31:0] mdl_start_ms;
	logic        mdl_wake_run;
	logic [7:0]  mdl_wake_cnt;
	logic        mdl_cmd_run;
	logic [7:0]  mdl_cmd_label;
	logic [2:0]  mdl_cmd_id;
	logic [7:0]  mdl_cmd_cnt;
	logic        mdl_light;
	logic        mdl_fan;

	result_t     status_q[$];
	result_t     oldest_status;
	int          mismatch_count = 0;
	int          items_sent = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          seg_count = 0;
	logic [31:0] tick_ms;

	function automatic void drop_wake();
		mdl_wake_run = 1'b0;
		mdl_wake_cnt = '0;
	endfunction

	function automatic void drop_cmd();
		mdl_cmd_run = 1'b0;
		mdl_cmd_label = '0;
		mdl_cmd_id = CMD_NONE;
		mdl_cmd_cnt = '0;
	endfunction

	// Model of one tick: timeout first, then the optional classifier result
	task automatic confirm_step(input item_t it, output result_t r);
		logic [31:0] elapsed;
		logic hit;
		logic [2:0] act;
		r = '0;
		r.command_outcome = OUT_NOTHING;
		elapsed = it.now_ms - mdl_start_ms;
		if (mdl_listening && elapsed >= cfg_shadow.listen_window_ms) begin
			mdl_listening = 1'b0;
			drop_wake();
			drop_cmd();
			r.timed_out = 1'b1;
		end
		if (it.mode) begin
			if (!mdl_listening) begin
				// wake frame counting while idle
				if (!it.is_wake) begin
					drop_wake();
					hit = 1'b0;
				end else if (!mdl_wake_run) begin
					mdl_wake_run = 1'b1;
					mdl_wake_cnt = 8'd1;
					hit = (cfg_shadow.wake_frames_needed <= 8'd1);
				end else begin
					if (mdl_wake_cnt < cfg_shadow.wake_frames_needed)
						mdl_wake_cnt++;
					hit = (mdl_wake_cnt >= cfg_shadow.wake_frames_needed);
				end
				if (hit) begin
					mdl_listening = 1'b1;
					mdl_start_ms = it.now_ms;
					drop_wake();
					drop_cmd();
					r.wake_activated = 1'b1;
				end
			end else if (elapsed >= cfg_shadow.cooldown_ms && !it.is_wake) begin
				// same-label command counting after the cooldown
				if (!it.has_command) begin
					drop_cmd();
					hit = 1'b0;
				end else if (!mdl_cmd_run || mdl_cmd_label != it.label_id) begin
					mdl_cmd_run = 1'b1;
					mdl_cmd_label = it.label_id;
					mdl_cmd_id = it.command_id;
					mdl_cmd_cnt = 8'd1;
					hit = (cfg_shadow.command_frames_needed <= 8'd1);
				end else begin
					if (mdl_cmd_cnt < cfg_shadow.command_frames_needed)
						mdl_cmd_cnt++;
					mdl_cmd_id = it.command_id;
					hit = (mdl_cmd_cnt >= cfg_shadow.command_frames_needed);
				end
				if (hit) begin
					act = mdl_cmd_id;
					mdl_listening = 1'b0;
					drop_wake();
					drop_cmd();
					case (act)
						CMD_NONE: r.command_outcome = OUT_NO_COMMAND;
						CMD_LIGHT_ON: begin
							mdl_light = 1'b1;
							r.command_outcome = OUT_LIGHT_ON;
						end
						CMD_LIGHT_OFF: begin
							mdl_light = 1'b0;
							r.command_outcome = OUT_LIGHT_OFF;
						end
						CMD_FAN_ON: begin
							mdl_fan = 1'b1;
							r.command_outcome = OUT_FAN_ON;
						end
						CMD_FAN_OFF: begin
							mdl_fan = 1'b0;
							r.command_outcome = OUT_FAN_OFF;
						end
						default: r.command_outcome = OUT_UNKNOWN;
					endcase
				end
			end
		end
		r.light_level = mdl_light;
		r.fan_level = mdl_fan;
		r.listening = mdl_listening;
	endtask

	function automatic item_t make_item(input logic m, input logic [31:0] t, input logic w,
			input logic hc, input logic [7:0] lbl, input logic [2:0] cmd);
		item_t it;
		it.mode = m;
		it.now_ms = t;
		it.is_wake = w;
		it.has_command = hc;
		it.label_id = lbl;
		it.command_id = cmd;
		return it;
	endfunction

	function automatic item_t noise_item(input logic [31:0] t);
		return make_item(1'($urandom_range(0, 1)), t, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
	endfunction

	// Send one item; called and returns at a falling edge
	task automatic send_item(input item_t it);
		result_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall !== 1'b0);
		confirm_step(it, r);
		status_q.push_back(r);
		items_sent++;
		@(negedge clk);
	endtask

	// Wait until every status has come back, plus pipeline slack
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (status_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_WAKE_FRAMES:    cfg_shadow.wake_frames_needed = val[7:0];
			CFG_COMMAND_FRAMES: cfg_shadow.command_frames_needed = val[7:0];
			CFG_LISTEN_WINDOW:  cfg_shadow.listen_window_ms = val;
			CFG_COOLDOWN:       cfg_shadow.cooldown_ms = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver stall
	always @(negedge clk) begin
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	function automatic void check_field(input string name, input logic [2:0] want,
			input logic [2:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Compare each accepted status with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (status_q.size() == 0) begin
				$display("%0t: unexpected result expected none got %h", $time, result);
				mismatch_count++;
			end else begin
				oldest_status = status_q.pop_front();
				check_field("timed_out", oldest_status.timed_out, result.timed_out);
				check_field("wake_activated", oldest_status.wake_activated,
					result.wake_activated);
				check_field("command_outcome", oldest_status.command_outcome,
					result.command_outcome);
				check_field("light_level", oldest_status.light_level, result.light_level);
				check_field("fan_level", oldest_status.fan_level, result.fan_level);
				check_field("listening", oldest_status.listening, result.listening);
			end
		end
	end

	// Default registers: wake and command counting, clock wrap, label change
	task automatic test_wake_and_command();
		logic [31:0] t0;
		t0 = 32'hFFFF_FF00;
		send_item(make_item(1'b0, t0, 1'b1, 1'b1, 8'hFF, CMD_ID_RSVD7));
		send_item(make_item(1'b1, t0 + 10, 1'b1, 1'b0, 8'd0, CMD_NONE));
		send_item(make_item(1'b1, t0 + 20, 1'b0, 1'b0, 8'd0, CMD_NONE));
		send_item(make_item(1'b1, t0 + 30, 1'b1, 1'b0, 8'd1, CMD_NONE));
		send_item(make_item(1'b1, t0 + 40, 1'b1, 1'b1, 8'd2, CMD_FAN_ON));
		send_item(make_item(1'b1, t0 + 50, 1'b1, 1'b0, 8'd3, CMD_NONE));
		// still in cooldown: ignored
		send_item(make_item(1'b1, t0 + 100, 1'b0, 1'b1, 8'd7, CMD_LIGHT_ON));
		// wake frames are ignored while listening
		send_item(make_item(1'b1, t0 + 650, 1'b1, 1'b1, 8'd7, CMD_LIGHT_ON));
		send_item(make_item(1'b1, t0 + 650, 1'b0, 1'b1, 8'd7, CMD_LIGHT_ON));
		send_item(make_item(1'b1, t0 + 660, 1'b0, 1'b1, 8'd7, CMD_LIGHT_ON));
		// label change restarts the count
		send_item(make_item(1'b1, t0 + 670, 1'b0, 1'b1, 8'd9, CMD_FAN_ON));
		send_item(make_item(1'b1, t0 + 680, 1'b0, 1'b1, 8'd9, CMD_FAN_ON));
		// same label: latest command wins
		send_item(make_item(1'b1, t0 + 690, 1'b0, 1'b1, 8'd9, CMD_LIGHT_ON));
	endtask

	// Timeout with wake on one item, cleared count, no-command and unknown ids
	task automatic test_special_cases();
		logic [31:0] t0;
		wait_idle();
		write_reg(CFG_WAKE_FRAMES, 32'hABCD_EF00);
		write_reg(CFG_COMMAND_FRAMES, 32'd2);
		write_reg(CFG_LISTEN_WINDOW, 32'd1000);
		write_reg(CFG_COOLDOWN, 32'd0);
		t0 = 32'h7FFF_FC00;
		send_item(make_item(1'b1, t0, 1'b1, 1'b0, 8'd0, CMD_NONE));
		send_item(make_item(1'b1, t0 + 1000, 1'b1, 1'b0, 8'd0, CMD_NONE));
		send_item(make_item(1'b1, t0 + 1001, 1'b0, 1'b1, 8'd3, CMD_FAN_ON));
		send_item(make_item(1'b1, t0 + 1002, 1'b0, 1'b0, 8'd3, CMD_FAN_ON));
		send_item(make_item(1'b1, t0 + 1003, 1'b0, 1'b1, 8'd3, CMD_FAN_ON));
		send_item(make_item(1'b1, t0 + 1004, 1'b0, 1'b1, 8'd3, CMD_FAN_ON));
		send_item(make_item(1'b1, t0 + 1010, 1'b1, 1'b0, 8'd0, CMD_NONE));
		send_item(make_item(1'b1, t0 + 1011, 1'b0, 1'b1, 8'd4, CMD_NONE));
		send_item(make_item(1'b1, t0 + 1012, 1'b0, 1'b1, 8'd4, CMD_NONE));
		send_item(make_item(1'b1, t0 + 1020, 1'b1, 1'b0, 8'd0, CMD_NONE));
		send_item(make_item(1'b1, t0 + 1021, 1'b0, 1'b1, 8'd5, CMD_ID_RSVD6));
		send_item(make_item(1'b1, t0 + 1022, 1'b0, 1'b1, 8'd5, CMD_ID_RSVD6));
	endtask

	// Widest frame counts with an endless window and no cooldown
	task automatic test_long_counts();
		logic [7:0] lbl;
		wait_idle();
		write_reg(CFG_WAKE_FRAMES, 32'd255);
		write_reg(CFG_COMMAND_FRAMES, 32'd255);
		write_reg(CFG_LISTEN_WINDOW, 32'hFFFF_FFFF);
		write_reg(CFG_COOLDOWN, 32'd0);
		tick_ms = $urandom;
		// broken wake run, then a full one
		repeat (100) begin
			send_item(make_item(1'b1, tick_ms, 1'b1, 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
			tick_ms += $urandom_range(0, 3);
		end
		send_item(make_item(1'b1, tick_ms, 1'b0, 1'b0, 8'($urandom_range(0, 255)), CMD_NONE));
		repeat (255) begin
			send_item(make_item(1'b1, tick_ms, 1'b1, 1'($urandom_range(0, 1)),
				8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
			tick_ms += $urandom_range(0, 3);
		end
		lbl = 8'($urandom_range(0, 255));
		repeat (256) begin
			send_item(make_item(1'b1, tick_ms, 1'b0, 1'b1, lbl, 3'($urandom_range(0, 7))));
			tick_ms += $urandom_range(0, 3);
		end
	endtask

	// One wake-then-command attempt with random content and some noise
	task automatic run_session();
		int n;
		logic [7:0] lbl;
		if ($urandom_range(0, 19) == 0)
			tick_ms = $urandom;
		n = (cfg_shadow.wake_frames_needed <= 8'd1) ? 1 : int'(cfg_shadow.wake_frames_needed);
		n += $urandom_range(0, 1);
		repeat (n) begin
			if ($urandom_range(0, 9) == 0)
				send_item(noise_item(tick_ms));
			else
				send_item(make_item(1'b1, tick_ms, 1'b1, 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 3'($urandom_range(0, 7))));
			tick_ms += $urandom_range(0, 30);
		end
		if ($urandom_range(0, 4) == 0) begin
			// let the window run out on bare ticks
			repeat (3) begin
				tick_ms += (cfg_shadow.listen_window_ms >> 1) + 1;
				send_item(make_item(1'b0, tick_ms, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					3'($urandom_range(0, 7))));
			end
		end else begin
			if (cfg_shadow.cooldown_ms <= 32'd1000)
				tick_ms += cfg_shadow.cooldown_ms;
			lbl = 8'($urandom_range(0, 255));
			n = (cfg_shadow.command_frames_needed <= 8'd1) ? 1 :
				int'(cfg_shadow.command_frames_needed);
			n += $urandom_range(0, 1);
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					send_item(noise_item(tick_ms));
				else if ($urandom_range(0, 9) == 0)
					send_item(make_item(1'b1, tick_ms, 1'b0, 1'b1, 8'($urandom_range(0, 255)),
						3'($urandom_range(0, 7))));
				else
					send_item(make_item(1'b1, tick_ms, 1'b0, 1'b1, lbl,
						3'($urandom_range(0, 7))));
				tick_ms += $urandom_range(0, 30);
			end
		end
	endtask

	// Random sessions under one idle/stall mix, new registers every segment
	task automatic test_random_traffic(input int send_pct, input int stall_pct, input int quota);
		int phase_start;
		int seg_start;
		logic [7:0] wn;
		logic [7:0] cn;
		logic [31:0] cool;
		logic [31:0] win;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
		phase_start = items_sent;
		while (items_sent - phase_start < quota) begin
			wait_idle();
			seg_count++;
			wn = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
			cn = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 4));
			cool = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom_range(0, 300));
			win = cool + $urandom_range(50, 3000);
			if ($urandom_range(0, 7) == 0 || seg_count == 1)
				win = 32'd0;
			if (seg_count == 5)
				cool = 32'hFFFF_FFFF;
			// upper data bits of the byte registers are don't-care
			write_reg(CFG_WAKE_FRAMES, ($urandom & 32'hFFFF_FF00) | 32'(wn));
			write_reg(CFG_COMMAND_FRAMES, ($urandom & 32'hFFFF_FF00) | 32'(cn));
			write_reg(CFG_LISTEN_WINDOW, win);
			write_reg(CFG_COOLDOWN, cool);
			tick_ms = $urandom;
			seg_start = items_sent;
			while (items_sent - seg_start < 110 && items_sent - phase_start < quota)
				run_session();
		end
	endtask

	// Main sequence
	initial begin
		cfg_shadow.wake_frames_needed = WakeFramesRst;
		cfg_shadow.command_frames_needed = CommandFramesRst;
		cfg_shadow.listen_window_ms = ListenWindowRst;
		cfg_shadow.cooldown_ms = CooldownRst;
		mdl_listening = 1'b0;
		mdl_start_ms = '0;
		drop_wake();
		drop_cmd();
		mdl_light = 1'b0;
		mdl_fan = 1'b0;
		tick_ms = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_wake_and_command();
		test_special_cases();
		test_long_counts();
		test_random_traffic(0, 0, 330);
		test_random_traffic(54, 0, 330);
		test_random_traffic(0, 54, 330);
		test_random_traffic(8, 8, 330);

		wait_idle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
